/* sv/char_lcd_nibble_write_sequencer_core_macros.svh */
// Assertion macros for the LCD nibble write sequencer.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication.
`define CLNWS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CLNWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/clnws_pkg.sv */
// Types and constants shared by the LCD nibble write sequencer.
`timescale 1ns / 1ps
package clnws_pkg;

    localparam int COLUMNS = 16;

    localparam logic [13:0] T_SETUP   = 14'd20;
    localparam logic [13:0] T_EN_HIGH = 14'd40;
    localparam logic [13:0] T_EN_LOW  = 14'd5;
    localparam logic [13:0] T_SHORT   = 14'd50;
    localparam logic [13:0] T_LONG    = 14'd1600;
    localparam logic [13:0] T_POWERUP = 14'd16000;

    localparam logic [2:0] STEP_HI_SETUP  = 3'd0;
    localparam logic [2:0] STEP_HI_EN_LOW = 3'd2;
    localparam logic [2:0] STEP_POST      = 3'd6;
    localparam logic [2:0] INIT_LAST_BYTE = 3'd6;

    typedef enum logic [2:0] {
        OP_INIT     = 3'd0,
        OP_DISP_ON  = 3'd1,
        OP_DISP_OFF = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_HOME     = 3'd4,
        OP_CURSOR   = 3'd5,
        OP_PRINT    = 3'd6
    } op_t;

    typedef struct packed {
        logic [2:0] operation;
        logic       row;
        logic [3:0] col;
        logic [7:0] character;
    } in_t;

    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic        enable;
        logic [13:0] hold_us;
        logic        last;
    } out_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic       powerup;
        logic [2:0] byte_idx;
        logic [2:0] step;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic op_init;
        logic op_byte;
        logic high_only;
    } stat_t;

endpackage

/* sv/clnws_ctrl.sv */
// Controller state machine that walks the bytes and pin steps of an operation.
`timescale 1ns / 1ps
module clnws_ctrl
    import clnws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POWERUP,
        ST_BYTE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] byte_reg, byte_next;
    logic [2:0] step_reg, step_next;
    logic       last_byte;

    assign last_byte = !stat.op_init || (byte_reg == INIT_LAST_BYTE);

    always_comb
    begin
        state_next   = state_reg;
        byte_next    = byte_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.byte_idx = byte_reg;
        cmd.step     = step_reg;
        cmd.last     = (step_reg == STEP_POST) && last_byte;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                byte_next = '0;
                step_next = STEP_HI_SETUP;
                if (stat.op_init)
                begin
                    state_next = ST_POWERUP;
                end
                else if (stat.op_byte)
                begin
                    state_next = ST_BYTE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POWERUP:
            begin
                cmd.emit    = stat.out_free;
                cmd.powerup = 1'b1;
                cmd.last    = 1'b0;
                if (stat.out_free)
                begin
                    state_next = ST_BYTE;
                end
            end
            ST_BYTE:
            begin
                cmd.emit = stat.out_free;
                if (stat.out_free)
                begin
                    if (step_reg == STEP_POST)
                    begin
                        if (last_byte)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            byte_next = byte_reg + 3'd1;
                            step_next = STEP_HI_SETUP;
                        end
                    end
                    else if ((step_reg == STEP_HI_EN_LOW) && stat.high_only)
                    begin
                        step_next = STEP_POST;
                    end
                    else
                    begin
                        step_next = step_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            byte_reg  <= '0;
            step_reg  <= '0;
            in_stall  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            byte_reg  <= byte_next;
            step_reg  <= step_next;
            in_stall  <= (state_next != ST_IDLE);
        end
    end

endmodule

/* sv/clnws_datapath.sv */
// Datapath: operation latch, byte selection, pin state build and output register.
`timescale 1ns / 1ps
module clnws_datapath
    import clnws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  in_t   in_data,
    input  logic  out_stall,
    output logic  out_valid,
    output out_t  out_data,
    input  cmd_t  cmd,
    output stat_t stat
);

    localparam logic [7:0] CMD_FUNC_8BIT = 8'h30;
    localparam logic [7:0] CMD_FUNC_4BIT = 8'h2C;
    localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_HOME      = 8'h03;
    localparam logic [7:0] CMD_LINE1     = 8'h80;
    localparam logic [7:0] CMD_LINE2     = 8'hC0;

    in_t         op_reg;
    logic        out_valid_reg, out_valid_next;
    out_t        out_data_reg, out_data_next;
    logic [3:0]  col_mod;
    logic [7:0]  value;
    logic        rs;
    logic        high_only;
    logic [13:0] post;
    out_t        pin;

    assign col_mod = (32'(op_reg.col) >= COLUMNS) ? (op_reg.col - 4'(COLUMNS)) : op_reg.col;

    always_comb
    begin
        value     = '0;
        rs        = 1'b0;
        high_only = 1'b0;
        post      = T_SHORT;
        case (op_reg.operation)
            OP_INIT:
            begin
                case (cmd.byte_idx)
                    3'd0: value = CMD_FUNC_8BIT;
                    3'd1:
                    begin
                        value     = CMD_FUNC_4BIT;
                        high_only = 1'b1;
                    end
                    3'd2: value = CMD_FUNC_4BIT;
                    3'd3: value = CMD_DISP_OFF;
                    3'd4:
                    begin
                        value = CMD_CLEAR;
                        post  = T_LONG;
                    end
                    3'd5: value = CMD_ENTRY;
                    default: value = CMD_DISP_ON;
                endcase
            end
            OP_DISP_ON:  value = CMD_DISP_ON;
            OP_DISP_OFF: value = CMD_DISP_OFF;
            OP_CLEAR:
            begin
                value = CMD_CLEAR;
                post  = T_LONG;
            end
            OP_HOME:
            begin
                value = CMD_HOME;
                post  = T_LONG;
            end
            OP_CURSOR:   value = (op_reg.row ? CMD_LINE2 : CMD_LINE1) + {4'd0, col_mod};
            OP_PRINT:
            begin
                value = op_reg.character;
                rs    = 1'b1;
            end
            default:     value = '0;
        endcase
    end

    always_comb
    begin
        pin            = '0;
        pin.reg_select = rs;
        pin.last       = cmd.last;
        if (cmd.powerup)
        begin
            pin.reg_select = 1'b0;
            pin.hold_us    = T_POWERUP;
        end
        else
        begin
            case (cmd.step)
                3'd0, 3'd3: pin.hold_us = T_SETUP;
                3'd1:
                begin
                    pin.nibble  = value[7:4];
                    pin.enable  = 1'b1;
                    pin.hold_us = T_EN_HIGH;
                end
                3'd2:
                begin
                    pin.nibble  = value[7:4];
                    pin.hold_us = T_EN_LOW;
                end
                3'd4:
                begin
                    pin.nibble  = value[3:0];
                    pin.enable  = 1'b1;
                    pin.hold_us = T_EN_HIGH;
                end
                3'd5:
                begin
                    pin.nibble  = value[3:0];
                    pin.hold_us = T_EN_LOW;
                end
                default: pin.hold_us = post;
            endcase
        end
    end

    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.op_init   = (op_reg.operation == OP_INIT);
    assign stat.op_byte   = (op_reg.operation != OP_INIT) && (op_reg.operation <= OP_PRINT);
    assign stat.high_only = high_only;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = pin;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (cmd.load)
        begin
            op_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sv/char_lcd_nibble_write_sequencer_core.sv */
// Top level of the LCD nibble write sequencer: controller plus datapath.
// Input channel (in_valid / in_stall / in_data): one beat carries one operation
// (init, display on/off, clear, home, cursor, print) with row, col, character.
// Output channel (out_valid / out_stall / out_data): one beat per pin state on the
// 4-bit LCD bus (reg_select, nibble, enable, hold_us, last); last marks the
// final pin state of the operation.
// An operation is taken in the idle state and decoded in the cycle after, then its
// pin states leave the output register one per cycle while the output does not
// stall: 7 beats for a single byte, 47 for init, none for operation code 7. The
// input stalls while an operation is being sequenced and reopens as soon as the
// last beat sits in the output register.
// A stall on the output holds the current beat and freezes the sequencer.
// Reset (rst_n low, asynchronous) empties the output register and returns the
// controller to idle with the input open.
`timescale 1ns / 1ps
`include "char_lcd_nibble_write_sequencer_core_macros.svh"
module char_lcd_nibble_write_sequencer_core
    import clnws_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    cmd_t  cmd;
    stat_t stat;

    clnws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    clnws_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    `CLNWS_ASSERT_NOW(a_emit_free, cmd.emit, stat.out_free, "emit over a held beat")
    `CLNWS_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "input open after accept")
    `CLNWS_ASSERT_NEXT(a_last_reopen, cmd.emit && cmd.last, !in_stall, "input closed after last beat")
    `CLNWS_ASSERT_NOW(a_strobe_hold, out_valid && out_data.enable, out_data.hold_us == T_EN_HIGH,
        "enable beat with wrong hold")

endmodule

/* bench/tb_char_lcd_nibble_write_sequencer_core.sv */
// Self-checking testbench for the LCD nibble write sequencer core.
`timescale 1ns / 1ps
module tb_char_lcd_nibble_write_sequencer_core;
    import clnws_pkg::*;

    localparam logic [2:0] OP_UNDEFINED = 3'd7;
    localparam logic [13:0] SETUP_US = 14'd20;
    localparam logic [13:0] STROBE_HIGH_US = 14'd40;
    localparam logic [13:0] STROBE_LOW_US = 14'd5;
    localparam logic [13:0] SHORT_US = 14'd50;
    localparam logic [13:0] LONG_US = 14'd1600;
    localparam logic [13:0] POWERUP_US = 14'd16000;
    localparam int LINE_COLS = 16;
    localparam int RANDOM_OPS = 440;
    localparam int DRAIN_CYCLES = 80;
    localparam int DIRECTED_ROWS = 18;

    typedef struct packed {
        logic [2:0]  op;
        logic        row;
        logic [3:0]  col;
        logic [7:0]  ch;
        logic        typed;
        logic        silent;
        logic        rs;
        logic [7:0]  code;
        logic [13:0] post;
    } directed_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    out_t pin_state_q[$];
    out_t op_states[$];
    out_t want;
    int fail_count = 0;
    int stall_left = 0;
    int stall_pick;

    directed_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{OP_INIT,     1'b0, 4'd0,  8'h00, 1'b0, 1'b0, 1'b0, 8'h00, SHORT_US},
        '{OP_DISP_ON,  1'b0, 4'd0,  8'h00, 1'b1, 1'b0, 1'b0, 8'h0C, SHORT_US},
        '{OP_DISP_OFF, 1'b1, 4'd15, 8'hFF, 1'b1, 1'b0, 1'b0, 8'h08, SHORT_US},
        '{OP_CLEAR,    1'b0, 4'd0,  8'h00, 1'b1, 1'b0, 1'b0, 8'h01, LONG_US},
        '{OP_HOME,     1'b1, 4'd15, 8'hFF, 1'b1, 1'b0, 1'b0, 8'h03, LONG_US},
        '{OP_CURSOR,   1'b0, 4'd0,  8'h00, 1'b1, 1'b0, 1'b0, 8'h80, SHORT_US},
        '{OP_CURSOR,   1'b0, 4'd15, 8'hFF, 1'b1, 1'b0, 1'b0, 8'h8F, SHORT_US},
        '{OP_CURSOR,   1'b1, 4'd0,  8'h00, 1'b1, 1'b0, 1'b0, 8'hC0, SHORT_US},
        '{OP_CURSOR,   1'b1, 4'd15, 8'hFF, 1'b1, 1'b0, 1'b0, 8'hCF, SHORT_US},
        '{OP_PRINT,    1'b0, 4'd0,  8'h00, 1'b1, 1'b0, 1'b1, 8'h00, SHORT_US},
        '{OP_PRINT,    1'b1, 4'd15, 8'hFF, 1'b1, 1'b0, 1'b1, 8'hFF, SHORT_US},
        '{OP_PRINT,    1'b1, 4'd9,  8'h41, 1'b0, 1'b0, 1'b0, 8'h00, SHORT_US},
        '{OP_UNDEFINED, 1'b1, 4'd15, 8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, SHORT_US},
        '{OP_UNDEFINED, 1'b0, 4'd0, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, SHORT_US},
        '{OP_CURSOR,   1'b1, 4'd5,  8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, SHORT_US},
        '{OP_PRINT,    1'b0, 4'd10, 8'hA5, 1'b0, 1'b0, 1'b0, 8'h00, SHORT_US},
        '{OP_INIT,     1'b1, 4'd15, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, SHORT_US},
        '{OP_CLEAR,    1'b1, 4'd7,  8'h5A, 1'b0, 1'b0, 1'b0, 8'h00, SHORT_US}
    };

    char_lcd_nibble_write_sequencer_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always #5 clk = ~clk;

    function automatic void add_state(logic rs, logic [3:0] nib, logic en, logic [13:0] hold);
        out_t s;
        s = '{reg_select: rs, nibble: nib, enable: en, hold_us: hold, last: 1'b0};
        op_states.push_back(s);
    endfunction

    function automatic void add_byte_run(logic rs, logic [7:0] code, logic high_only,
                                         logic [13:0] post);
        add_state(rs, 4'd0, 1'b0, SETUP_US);
        add_state(rs, code[7:4], 1'b1, STROBE_HIGH_US);
        add_state(rs, code[7:4], 1'b0, STROBE_LOW_US);
        if (!high_only)
        begin
            add_state(rs, 4'd0, 1'b0, SETUP_US);
            add_state(rs, code[3:0], 1'b1, STROBE_HIGH_US);
            add_state(rs, code[3:0], 1'b0, STROBE_LOW_US);
        end
        add_state(rs, 4'd0, 1'b0, post);
    endfunction

    // flag the final pin state of the operation and queue the run
    function automatic void commit_op_states();
        out_t s;
        for (int i = 0; i < op_states.size(); i++)
        begin
            s = op_states[i];
            s.last = (i == op_states.size() - 1);
            pin_state_q.push_back(s);
        end
        op_states.delete();
    endfunction

    function automatic void predict_pin_states(in_t item);
        logic [7:0] addr;
        case (item.operation)
            OP_INIT:
            begin
                add_state(1'b0, 4'd0, 1'b0, POWERUP_US);
                add_byte_run(1'b0, 8'h30, 1'b0, SHORT_US);
                add_byte_run(1'b0, 8'h2C, 1'b1, SHORT_US);
                add_byte_run(1'b0, 8'h2C, 1'b0, SHORT_US);
                add_byte_run(1'b0, 8'h08, 1'b0, SHORT_US);
                add_byte_run(1'b0, 8'h01, 1'b0, LONG_US);
                add_byte_run(1'b0, 8'h06, 1'b0, SHORT_US);
                add_byte_run(1'b0, 8'h0C, 1'b0, SHORT_US);
            end
            OP_DISP_ON:  add_byte_run(1'b0, 8'h0C, 1'b0, SHORT_US);
            OP_DISP_OFF: add_byte_run(1'b0, 8'h08, 1'b0, SHORT_US);
            OP_CLEAR:    add_byte_run(1'b0, 8'h01, 1'b0, LONG_US);
            OP_HOME:     add_byte_run(1'b0, 8'h03, 1'b0, LONG_US);
            OP_CURSOR:
            begin
                addr = (item.row ? 8'hC0 : 8'h80) + 8'(item.col % LINE_COLS);
                add_byte_run(1'b0, addr, 1'b0, SHORT_US);
            end
            OP_PRINT:    add_byte_run(1'b1, item.character, 1'b0, SHORT_US);
            default:;
        endcase
        commit_op_states();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // hold the beat until accepted
    task automatic send_op(input in_t item);
        in_data <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // idle for a random gap
    task automatic idle_gap();
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 60)
            begin
                out_stall <= 1'b0;
                stall_left <= $urandom_range(0, 3);
            end
            else if (stall_pick < 90)
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else if (stall_pick < 96)
            begin
                out_stall <= 1'b0;
                stall_left <= $urandom_range(20, 120);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pin_state_q.size() == 0)
            begin
                $error("unexpected pin state beat %p", out_data);
                fail_count++;
            end
            else
            begin
                want = pin_state_q.pop_front();
                if (out_data.reg_select !== want.reg_select)
                begin
                    $error("reg_select: expected %0d, got %0d", want.reg_select,
                           out_data.reg_select);
                    fail_count++;
                end
                if (out_data.nibble !== want.nibble)
                begin
                    $error("nibble: expected %0h, got %0h", want.nibble, out_data.nibble);
                    fail_count++;
                end
                if (out_data.enable !== want.enable)
                begin
                    $error("enable: expected %0d, got %0d", want.enable, out_data.enable);
                    fail_count++;
                end
                if (out_data.hold_us !== want.hold_us)
                begin
                    $error("hold_us: expected %0d, got %0d", want.hold_us, out_data.hold_us);
                    fail_count++;
                end
                if (out_data.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, out_data.last);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        in_t item;
        directed_t row;
        int pick;
        int sent;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            item = '{operation: row.op, row: row.row, col: row.col, character: row.ch};
            send_op(item);
            if (row.typed)
            begin
                if (!row.silent)
                begin
                    add_byte_run(row.rs, row.code, 1'b0, row.post);
                    commit_op_states();
                end
            end
            else
                predict_pin_states(item);
            idle_gap();
        end

        sent = 0;
        while (sent < RANDOM_OPS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                item.operation = OP_INIT;
            else if (pick < 12)
                item.operation = OP_UNDEFINED;
            else
                item.operation = 3'($urandom_range(1, 6));
            item.row = 1'($urandom);
            item.col = 4'($urandom);
            item.character = 8'($urandom);
            send_op(item);
            predict_pin_states(item);
            idle_gap();
            if (item.operation != OP_UNDEFINED)
                sent++;
        end

        in_valid <= 1'b0;
        while (pin_state_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_char_lcd_nibble_write_sequencer_core passed");
        else
            $display("tb_char_lcd_nibble_write_sequencer_core failed");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("tb_char_lcd_nibble_write_sequencer_core failed");
        $finish;
    end

endmodule
